@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, quiet while reset is high
`define SSE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sse_pkg.sv @@
package sse_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int COUNT_W  = 7;
   localparam int VALUE_W  = 32;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_CONTAINS = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [VALUE_W-1:0] value;
   } sse_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
   } sse_rsp_type;

   // per-cycle commands broadcast along the row of cells
   typedef struct packed {
      logic load;   // latch compare flags against the incoming value
      logic ins;    // open a gap at the insert point, shift upwards
      logic del;    // close the gap at the match, shift downwards
   } sse_cell_ctl_type;

endpackage

@@ rtl/sse_cell.sv @@
module sse_cell (
   input  logic                                clock,
   input  sse_pkg::sse_cell_ctl_type           ctl,
   input  logic                                occupied,
   input  logic signed [sse_pkg::VALUE_W-1:0]  probe_value,
   input  logic signed [sse_pkg::VALUE_W-1:0]  left_entry,
   input  logic                                left_lt,
   input  logic signed [sse_pkg::VALUE_W-1:0]  right_entry,
   output logic signed [sse_pkg::VALUE_W-1:0]  entry,
   output logic                                lt,
   output logic                                eq
);
   import sse_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;

   always_comb begin
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      entry_in = entry_ff;
      if (ctl.load) begin
         lt_in = occupied && (entry_ff < probe_value);
         eq_in = occupied && (entry_ff == probe_value);
      end
      // cells below the insert or match point keep their entry
      if (ctl.ins && !lt_ff) begin
         entry_in = left_lt ? probe_value : left_entry;
      end else if (ctl.del && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

@@ rtl/sorted_set_engine_top.sv @@
// channel   ports                     direction  handshake
// request   req_item                  in         start high while busy low
// response  rsp_item                  out        rsp_strobe, one cycle, no back-pressure
//
// an item is handled in order: the accept edge latches compare flags in every cell,
// the next edge shifts the row, updates the count and registers the result,
// which stays on rsp_item until the next result is registered
// busy is high for the one cycle between accept and shift; the next item may be
// started while the previous result is on rsp_item
// synchronous reset clears the count and the control flags; entries are left as they are
module sorted_set_engine_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sse_pkg::sse_req_type  req_item,
   output logic                  rsp_strobe,
   output sse_pkg::sse_rsp_type  rsp_item
);
   import sse_pkg::*;
   `include "assert_macros.svh"

   logic                      busy_ff, busy_in;
   logic                      strobe_ff, strobe_in;
   sse_req_type               req_ff, req_in;
   sse_rsp_type               rsp_ff, rsp_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;

   logic                      accept;
   logic                      present;
   logic                      ins_go, del_go;
   sse_cell_ctl_type          ctl;
   logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0]       cell_lt;
   logic [CAPACITY-1:0]       cell_eq;
   logic signed [VALUE_W-1:0] probe;

   assign accept  = start && !busy_ff;
   assign present = |cell_eq;
   // during the compare edge the cells see the incoming value, afterwards the held one
   assign probe   = busy_ff ? req_ff.value : req_item.value;

   assign ins_go = busy_ff && (req_ff.opcode == OP_INSERT) && !present
                   && (occ_ff < CNT_W'(CAPACITY));
   assign del_go = busy_ff && (req_ff.opcode == OP_REMOVE) && present;

   assign ctl.load = accept;
   assign ctl.ins  = ins_go;
   assign ctl.del  = del_go;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_e, right_e;
      logic                      left_l;
      if (i == 0) begin : g_head
         assign left_e = probe;
         assign left_l = 1'b1;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_l = cell_lt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      sse_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occ_ff > CNT_W'(i)),
         .probe_value (probe),
         .left_entry  (left_e),
         .left_lt     (left_l),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i])
      );
   end

   always_comb begin
      busy_in   = busy_ff;
      strobe_in = busy_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      occ_in    = occ_ff;
      if (accept) begin
         busy_in = 1'b1;
         req_in  = req_item;
      end
      if (busy_ff) begin
         busy_in = 1'b0;
         if (ins_go) begin
            occ_in = occ_ff + CNT_W'(1);
         end else if (del_go) begin
            occ_in = occ_ff - CNT_W'(1);
         end
         case (req_ff.opcode)
            OP_INSERT: begin
               if (present) begin
                  rsp_in.status = ST_MISS;
               end else if (ins_go) begin
                  rsp_in.status = ST_DONE;
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end
            OP_REMOVE, OP_CONTAINS: rsp_in.status = present ? ST_DONE : ST_MISS;
            default:                rsp_in.status = ST_MISS;
         endcase
         rsp_in.count     = COUNT_W'(occ_in);
         rsp_in.empty_res = (occ_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         occ_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
         occ_ff    <= occ_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `SSE_ASSERT_NEXT(a_accept_busy, accept, busy_ff, "accepted item did not raise busy")
   `SSE_ASSERT_NEXT(a_work_strobe, busy_ff, strobe_ff && !busy_ff, "work cycle gave no result")
   `SSE_ASSERT_SAME(a_occ_bound, 1'b1, occ_ff <= CNT_W'(CAPACITY), "count beyond capacity")
   `SSE_ASSERT_SAME(a_single_match, busy_ff, $onehot0(cell_eq), "value held in two cells")
   `SSE_ASSERT_SAME(a_empty_flag, strobe_ff, rsp_ff.empty_res == (occ_ff == '0),
                    "empty flag disagrees with count")

endmodule

@@ bench/sse_check_pkg.sv @@
package sse_check_pkg;

   import sse_pkg::*;

   // opcode the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   class set_scoreboard;

      logic signed [VALUE_W-1:0] held[CAPACITY];
      int                        occupancy;
      sse_rsp_type               awaited[$];
      int                        errors;

      function new();
         occupancy = 0;
         errors    = 0;
      endfunction

      // run the item against the local copy of the set and queue its result
      function void note_item(sse_req_type item);
         int          pos;
         int          i;
         bit          present;
         sse_rsp_type exp;
         pos = 0;
         while (pos < occupancy && held[pos] < item.value)
            pos++;
         present = (pos < occupancy) && (held[pos] == item.value);
         exp.status = ST_MISS;
         case (item.opcode)
            OP_INSERT: begin
               if (present) begin
                  exp.status = ST_MISS;
               end else if (occupancy >= CAPACITY) begin
                  exp.status = ST_FULL;
               end else begin
                  for (i = occupancy; i > pos; i--)
                     held[i] = held[i-1];
                  held[pos] = item.value;
                  occupancy++;
                  exp.status = ST_DONE;
               end
            end
            OP_REMOVE: begin
               if (present) begin
                  for (i = pos; i + 1 < occupancy; i++)
                     held[i] = held[i+1];
                  occupancy--;
                  exp.status = ST_DONE;
               end
            end
            OP_CONTAINS: begin
               if (present)
                  exp.status = ST_DONE;
            end
            default: begin
            end
         endcase
         exp.count     = COUNT_W'(occupancy);
         exp.empty_res = (occupancy == 0);
         awaited.push_back(exp);
      endfunction

      function void check_result(sse_rsp_type got);
         sse_rsp_type exp;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result status=%0d count=%0d empty=%0d",
                     $time, got.status, got.count, got.empty_res);
            errors++;
            return;
         end
         exp = awaited.pop_front();
         if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
         end
         if (got.count !== exp.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp.count, got.count);
            errors++;
         end
         if (got.empty_res !== exp.empty_res) begin
            $display("%0t: empty expected %0d actual %0d", $time, exp.empty_res,
                     got.empty_res);
            errors++;
         end
      endfunction

      function logic signed [VALUE_W-1:0] any_held();
         return held[$urandom_range(0, occupancy - 1)];
      endfunction

   endclass

endpackage

@@ bench/tb_top.sv @@
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import sse_pkg::*;
   import sse_check_pkg::*;

   localparam int POOL_SIZE = 100;
   localparam int ITEM_GOAL = 1100;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   sse_req_type req_item;
   logic        rsp_strobe;
   sse_rsp_type rsp_item;

   set_scoreboard             sb;
   logic signed [VALUE_W-1:0] pool[POOL_SIZE];
   bit                        calm;
   int                        items_sent;

   sorted_set_engine_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

   // results first, so a stray result never meets an expectation queued at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_result(rsp_item);
         if (start && !busy)
            sb.note_item(req_item);
      end
   end

   // called just after a rising edge; returns just after the edge that takes the item
   task automatic send_item(logic [1:0] op, logic signed [VALUE_W-1:0] val);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_item.opcode <= op;
      req_item.value  <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(int held_pct);
      if (sb.occupancy > 0 && $urandom_range(0, 99) < held_pct)
         return sb.any_held();
      if ($urandom_range(0, 9) == 0)
         return $urandom;
      return pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [1:0] pick_op(int ins_pct, int rem_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         return OP_UNUSED;
      if (roll < ins_pct)
         return OP_INSERT;
      if (roll < ins_pct + rem_pct)
         return OP_REMOVE;
      return OP_CONTAINS;
   endfunction

   task automatic run_phase(int len, int ins_pct, int rem_pct, int held_pct);
      logic [1:0] op;
      calm = ($urandom_range(0, 3) == 0);
      repeat (len) begin
         op = pick_op(ins_pct, rem_pct);
         send_item(op, pick_value(op == OP_INSERT ? held_pct / 4 : held_pct));
      end
   endtask

   task automatic refresh_pool();
      int i;
      pool[0] = 32'sh8000_0000;
      pool[1] = 32'sh7fff_ffff;
      pool[2] = 32'sd0;
      pool[3] = -32'sd1;
      for (i = 4; i < POOL_SIZE; i++)
         pool[i] = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 200) - 100;
   endtask

   initial begin
      sb          = new();
      items_sent  = 0;
      calm        = 1'b0;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_item   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty set, extremes, duplicates, unused opcode, back down to empty
      send_item(OP_CONTAINS, 32'sd5);
      send_item(OP_REMOVE,   32'sd5);
      send_item(OP_INSERT,   32'sh7fff_ffff);
      send_item(OP_INSERT,   32'sh8000_0000);
      send_item(OP_INSERT,   32'sd0);
      send_item(OP_INSERT,   -32'sd1);
      send_item(OP_INSERT,   32'sd1);
      send_item(OP_INSERT,   32'sh7fff_ffff);
      send_item(OP_INSERT,   32'sh8000_0000);
      send_item(OP_CONTAINS, 32'sh8000_0000);
      send_item(OP_CONTAINS, 32'sh7fff_ffff);
      send_item(OP_CONTAINS, 32'sd5);
      send_item(OP_UNUSED,   32'sd0);
      send_item(OP_UNUSED,   32'sd77);
      send_item(OP_REMOVE,   32'sd0);
      send_item(OP_REMOVE,   32'sd0);
      send_item(OP_REMOVE,   32'sh8000_0000);
      send_item(OP_REMOVE,   32'sh7fff_ffff);
      send_item(OP_REMOVE,   -32'sd1);
      send_item(OP_REMOVE,   32'sd1);
      send_item(OP_CONTAINS, 32'sd1);

      // fill past capacity, churn, then drain towards empty
      while (items_sent < ITEM_GOAL) begin
         refresh_pool();
         run_phase(140, 88, 4, 20);
         run_phase(100, 40, 35, 60);
         run_phase(150, 5, 85, 75);
      end
      start <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
